// ===== hdl/dtes_pkg.sv =====
`timescale 1ns / 1ps
// Package for the depth triangle edge setup block.
// Holds widths, opcodes, divider latency and the side-path payload types.
package dtes_pkg;

    localparam int COORD_W = 14;               // vertex x/y, quarter pixels
    localparam int DIFF_W  = COORD_W + 1;      // coordinate difference
    localparam int Z_W     = 32;               // depth, s15.16
    localparam int ZDIFF_W = Z_W + 1;          // depth difference
    localparam int NUM_W   = 35;               // signed dividend
    localparam int MAG_W   = NUM_W - 1;        // dividend magnitude
    localparam int DMAG_W  = DIFF_W - 1;       // divisor magnitude
    localparam int PROD_W  = 2 * DIFF_W;       // cross product term
    localparam int WORD_W  = 32;
    localparam int DIV_LAT = MAG_W + 2;        // magnitude stage, bit stages, saturate
    localparam int NWORDS  = 12;
    localparam int CNT_W   = 4;

    localparam logic [7:0] OP_DEPTH = 8'h09;
    localparam logic [7:0] OP_FLAT  = 8'h08;
    localparam logic [CNT_W-1:0] NW_DEPTH = 4'd12;
    localparam logic [CNT_W-1:0] NW_FLAT  = 4'd8;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] y3;
        logic signed [DIFF_W-1:0]  dx31;
        logic signed [DIFF_W-1:0]  dy21;
        logic signed [DIFF_W-1:0]  dy31;
        logic signed [DIFF_W-1:0]  dx21;
        logic signed [Z_W-1:0]     z1;
    } t_side_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] y3;
        logic signed [Z_W-1:0]     z1;
        logic                      lft;
    } t_side_out;

endpackage

// ===== hdl/dtes_div.sv =====
`timescale 1ns / 1ps
// Pipelined signed divider, one quotient bit per stage, truncating,
// zero for a zero divisor, saturating to 32 bits. Uses dtes_pkg.
module dtes_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [dtes_pkg::NUM_W-1:0]   i_num,
    input  logic signed [dtes_pkg::DIFF_W-1:0]  i_den,
    output logic [dtes_pkg::WORD_W-1:0]         o_quot
);

    localparam int MW = dtes_pkg::MAG_W;
    localparam int DW = dtes_pkg::DMAG_W;

    logic [MW-1:0] r_num  [0:MW];
    logic [MW-1:0] r_q    [0:MW];
    logic [DW-1:0] r_rem  [0:MW];
    logic [DW-1:0] r_den  [0:MW];
    logic          r_neg  [0:MW];
    logic          r_zero [0:MW];
    logic [dtes_pkg::WORD_W-1:0] r_quot;

    logic [dtes_pkg::NUM_W-1:0]  n_nmag;
    logic [dtes_pkg::DIFF_W-1:0] n_dmag;

    assign n_nmag = i_num[dtes_pkg::NUM_W-1] ? dtes_pkg::NUM_W'(-i_num)
                                               : dtes_pkg::NUM_W'(i_num);
    assign n_dmag = i_den[dtes_pkg::DIFF_W-1] ? dtes_pkg::DIFF_W'(-i_den)
                                                : dtes_pkg::DIFF_W'(i_den);

    // take magnitudes and sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= n_nmag[MW-1:0];
            r_den[0]  <= n_dmag[DW-1:0];
            r_q[0]    <= '0;
            r_rem[0]  <= '0;
            r_neg[0]  <= i_num[dtes_pkg::NUM_W-1] ^ i_den[dtes_pkg::DIFF_W-1];
            r_zero[0] <= (i_den == '0);
        end
    end

    // restoring steps, one dividend bit each
    for (genvar k = 1; k <= MW; k++) begin : g_step
        logic [DW:0] n_trial;
        logic        n_ge;
        assign n_trial = {r_rem[k-1], r_num[k-1][MW-1]};
        assign n_ge    = (n_trial >= {1'b0, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? DW'(n_trial - {1'b0, r_den[k-1]}) : n_trial[DW-1:0];
                r_q[k]    <= {r_q[k-1][MW-2:0], n_ge};
                r_num[k]  <= {r_num[k-1][MW-2:0], 1'b0};
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    // apply sign and saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[MW]) begin
                r_quot <= '0;
            end else if (r_neg[MW]) begin
                if (r_q[MW] > MW'(64'h8000_0000)) begin
                    r_quot <= 32'h8000_0000;
                end else begin
                    r_quot <= 32'(-r_q[MW][31:0]);
                end
            end else begin
                if (r_q[MW] > MW'(64'h7FFF_FFFF)) begin
                    r_quot <= 32'h7FFF_FFFF;
                end else begin
                    r_quot <= r_q[MW][31:0];
                end
            end
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== hdl/dtes_side.sv =====
`timescale 1ns / 1ps
// Side path: cross product sign for the left-major flag, then a delay
// line that keeps vertex data aligned with the dividers. Uses dtes_pkg.
module dtes_side (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  dtes_pkg::t_side_in   i_data,
    output logic                 o_valid,
    output dtes_pkg::t_side_out  o_data
);

    localparam int DL = dtes_pkg::DIV_LAT - 2;

    logic signed [dtes_pkg::PROD_W-1:0] r_p1, r_p2;
    dtes_pkg::t_side_in  r_a;
    logic                r_a_valid;
    dtes_pkg::t_side_out r_line  [0:DL];
    logic                r_valid [0:DL];

    // products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= i_data.dx31 * i_data.dy21;
            r_p2 <= i_data.dy31 * i_data.dx21;
            r_a  <= i_data;
        end
    end

    // sign of the difference, then hold alongside the dividers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0].x1  <= r_a.x1;
            r_line[0].x2  <= r_a.x2;
            r_line[0].y1  <= r_a.y1;
            r_line[0].y2  <= r_a.y2;
            r_line[0].y3  <= r_a.y3;
            r_line[0].z1  <= r_a.z1;
            r_line[0].lft <= (r_p1 < r_p2);
            for (int k = 1; k <= DL; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            for (int k = 0; k <= DL; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_a_valid  <= i_valid;
            r_valid[0] <= r_a_valid;
            for (int k = 1; k <= DL; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    assign o_valid = r_valid[DL];
    assign o_data  = r_line[DL];

endmodule

// ===== hdl/depth_triangle_edge_setup.sv =====
`timescale 1ns / 1ps
// Triangle edge and depth slope setup, top level.
// Uses dtes_pkg, dtes_div and dtes_side.
//
// Input channel: one triangle (three vertices, x/y in signed quarter pixels,
// z in s15.16) per request, taken when i_in_valid is high and o_in_stall low.
// Output channel: one 32-bit command word per request, taken when
// o_out_valid is high and i_out_stall low; o_last_word marks the final word.
// A triangle gives eight words, or twelve in depth mode (four depth words).
// Config channel: i_cfg_valid/o_cfg_ready write depth_mode (bit 0 of
// i_cfg_data); ready is always high. Write it only while the block is idle.
//
// Pipeline: input/sort stage, difference stage, then six dividers of
// DIV_LAT stages (one quotient bit per bit stage) beside a cross-product path.
// A triangle passes the sort, difference, divider and serializer registers
// before its first word. Throughput: the output channel sends twelve words
// per triangle in depth mode, eight in flat mode; a new triangle enters every
// cycle until the output serializer is full, then the whole pipeline holds.
// Reset clears all valid bits and sets depth_mode to 1.
// When the receiver stalls, the current word holds and the pipeline freezes
// once a finished triangle is waiting behind the serializer.
module depth_triangle_edge_setup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [13:0] i_ax,
    input  logic signed [13:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [13:0] i_bx,
    input  logic signed [13:0] i_by_coord,
    input  logic signed [31:0] i_bz,
    input  logic signed [13:0] i_cx,
    input  logic signed [13:0] i_cy,
    input  logic signed [31:0] i_cz,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_command_word,
    output logic        o_last_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int CW = dtes_pkg::COORD_W;
    localparam int DW = dtes_pkg::DIFF_W;
    localparam int ZW = dtes_pkg::Z_W;

    // configuration
    logic r_depth_mode;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_depth_mode <= i_cfg_data;
        end
    end

    logic n_en;
    logic n_load;

    // sort stage: three stable compare-and-swap steps on y
    logic signed [CW-1:0] n_x [0:2];
    logic signed [CW-1:0] n_y [0:2];
    logic signed [ZW-1:0] n_z [0:2];
    always_comb begin
        logic signed [CW-1:0] tx, ty;
        logic signed [ZW-1:0] tz;
        tx = '0; ty = '0; tz = '0;
        n_x[0] = i_ax; n_y[0] = i_ay;       n_z[0] = i_az;
        n_x[1] = i_bx; n_y[1] = i_by_coord; n_z[1] = i_bz;
        n_x[2] = i_cx; n_y[2] = i_cy;       n_z[2] = i_cz;
        if (n_y[0] > n_y[1]) begin
            tx = n_x[0]; n_x[0] = n_x[1]; n_x[1] = tx;
            ty = n_y[0]; n_y[0] = n_y[1]; n_y[1] = ty;
            tz = n_z[0]; n_z[0] = n_z[1]; n_z[1] = tz;
        end
        if (n_y[1] > n_y[2]) begin
            tx = n_x[1]; n_x[1] = n_x[2]; n_x[2] = tx;
            ty = n_y[1]; n_y[1] = n_y[2]; n_y[2] = ty;
            tz = n_z[1]; n_z[1] = n_z[2]; n_z[2] = tz;
        end
        if (n_y[0] > n_y[1]) begin
            tx = n_x[0]; n_x[0] = n_x[1]; n_x[1] = tx;
            ty = n_y[0]; n_y[0] = n_y[1]; n_y[1] = ty;
            tz = n_z[0]; n_z[0] = n_z[1]; n_z[1] = tz;
        end
    end

    logic signed [CW-1:0] r_x1, r_x2, r_x3, r_y1, r_y2, r_y3;
    logic signed [ZW-1:0] r_z1, r_z2, r_z3;
    logic                 r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_x1 <= n_x[0]; r_x2 <= n_x[1]; r_x3 <= n_x[2];
            r_y1 <= n_y[0]; r_y2 <= n_y[1]; r_y3 <= n_y[2];
            r_z1 <= n_z[0]; r_z2 <= n_z[1]; r_z3 <= n_z[2];
        end
    end

    // difference stage
    logic signed [DW-1:0] r_dx32, r_dy32, r_dx31, r_dy31, r_dx21, r_dy21;
    logic signed [dtes_pkg::ZDIFF_W-1:0] r_dz21, r_dz31;
    dtes_pkg::t_side_in   r_side_in;
    logic                 r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_dx32 <= DW'(r_x3) - DW'(r_x2);
            r_dy32 <= DW'(r_y3) - DW'(r_y2);
            r_dx31 <= DW'(r_x3) - DW'(r_x1);
            r_dy31 <= DW'(r_y3) - DW'(r_y1);
            r_dx21 <= DW'(r_x2) - DW'(r_x1);
            r_dy21 <= DW'(r_y2) - DW'(r_y1);
            r_dz21 <= dtes_pkg::ZDIFF_W'(r_z2) - dtes_pkg::ZDIFF_W'(r_z1);
            r_dz31 <= dtes_pkg::ZDIFF_W'(r_z3) - dtes_pkg::ZDIFF_W'(r_z1);
            r_side_in.x1   <= r_x1;
            r_side_in.x2   <= r_x2;
            r_side_in.y1   <= r_y1;
            r_side_in.y2   <= r_y2;
            r_side_in.y3   <= r_y3;
            r_side_in.z1   <= r_z1;
            r_side_in.dx31 <= DW'(r_x3) - DW'(r_x1);
            r_side_in.dy21 <= DW'(r_y2) - DW'(r_y1);
            r_side_in.dy31 <= DW'(r_y3) - DW'(r_y1);
            r_side_in.dx21 <= DW'(r_x2) - DW'(r_x1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (n_en) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // dividend forms: x slopes scale by 2^16, depth slopes by 4
    logic signed [dtes_pkg::NUM_W-1:0] n_nx32, n_nx31, n_nx21, n_nz21, n_nz31;
    assign n_nx32 = {{4{r_dx32[DW-1]}}, r_dx32, 16'b0};
    assign n_nx31 = {{4{r_dx31[DW-1]}}, r_dx31, 16'b0};
    assign n_nx21 = {{4{r_dx21[DW-1]}}, r_dx21, 16'b0};
    assign n_nz21 = {r_dz21, 2'b0};
    assign n_nz31 = {r_dz31, 2'b0};

    logic [31:0] n_q3, n_q5, n_q7, n_q9, n_q10, n_q11;

    dtes_div u_div_w3  (.i_clk(i_clk), .i_en(n_en), .i_num(n_nx32), .i_den(r_dy32),
                        .o_quot(n_q3));
    dtes_div u_div_w5  (.i_clk(i_clk), .i_en(n_en), .i_num(n_nx31), .i_den(r_dy31),
                        .o_quot(n_q5));
    dtes_div u_div_w7  (.i_clk(i_clk), .i_en(n_en), .i_num(n_nx21), .i_den(r_dy21),
                        .o_quot(n_q7));
    dtes_div u_div_w9  (.i_clk(i_clk), .i_en(n_en), .i_num(n_nz21), .i_den(r_dx21),
                        .o_quot(n_q9));
    dtes_div u_div_w10 (.i_clk(i_clk), .i_en(n_en), .i_num(n_nz31), .i_den(r_dy31),
                        .o_quot(n_q10));
    dtes_div u_div_w11 (.i_clk(i_clk), .i_en(n_en), .i_num(n_nz21), .i_den(r_dy21),
                        .o_quot(n_q11));

    logic                n_side_valid;
    dtes_pkg::t_side_out n_side;

    dtes_side u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (r_s2_valid),
        .i_data  (r_side_in),
        .o_valid (n_side_valid),
        .o_data  (n_side)
    );

    // output serializer
    logic [31:0]                 r_words [0:dtes_pkg::NWORDS-1];
    logic [dtes_pkg::CNT_W-1:0]  r_cnt;
    logic [dtes_pkg::CNT_W-1:0]  r_n;
    logic                        r_out_valid;
    logic                        n_last;
    logic                        n_take;

    assign n_last = (r_cnt == r_n - 1'b1);
    assign n_take = r_out_valid && !i_out_stall;
    // advance the pipeline unless a finished triangle waits on a busy serializer
    assign n_en   = !n_side_valid || !r_out_valid || (n_take && n_last);
    assign n_load = n_en && n_side_valid;
    assign o_in_stall = !n_en;

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_words[0]  <= {(r_depth_mode ? dtes_pkg::OP_DEPTH : dtes_pkg::OP_FLAT),
                            n_side.lft, 9'b0, n_side.y3};
            r_words[1]  <= {2'b0, n_side.y2, 2'b0, n_side.y1};
            r_words[2]  <= {{4{n_side.x2[CW-1]}}, n_side.x2, 14'b0};
            r_words[3]  <= n_q3;
            r_words[4]  <= {{4{n_side.x1[CW-1]}}, n_side.x1, 14'b0};
            r_words[5]  <= n_q5;
            r_words[6]  <= {{4{n_side.x1[CW-1]}}, n_side.x1, 14'b0};
            r_words[7]  <= n_q7;
            r_words[8]  <= n_side.z1;
            r_words[9]  <= n_q9;
            r_words[10] <= n_q10;
            r_words[11] <= n_q11;
            r_n <= r_depth_mode ? dtes_pkg::NW_DEPTH : dtes_pkg::NW_FLAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
            r_cnt       <= '0;
        end else if (n_take) begin
            if (n_last) begin
                r_out_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command_word = r_words[r_cnt];
    assign o_last_word    = r_out_valid && n_last;

    // checks
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_cnt < r_n))
        else $error("word counter past end of triangle");

    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_word && !i_out_stall && !n_side_valid) |=> !o_out_valid)
        else $error("words continue after last word with nothing pending");

    a_hold_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_side_valid && r_out_valid && !o_last_word) |-> o_in_stall)
        else $error("pipeline advanced while serializer busy");

    a_count_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_n == dtes_pkg::NW_DEPTH || r_n == dtes_pkg::NW_FLAT))
        else $error("bad word count");

endmodule
